/* rtl/core/circuit_language_lexer_assert.svh */
// Assertion macros shared by the lexer checker.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef CIRCUIT_LANGUAGE_LEXER_ASSERT_SVH
`define CIRCUIT_LANGUAGE_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define CLL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cll_pkg.sv */
// Shared types, token codes and character-class functions for the lexer.
// No dependencies; used by the scanner, the token queue and the top level.
package cll_pkg;

  localparam int unsigned LineMaxDefault = 1024;
  localparam int unsigned ColW           = 11;
  localparam int unsigned CharW          = 8;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QueuePtrW      = $clog2(QueueDepth);
  localparam int unsigned QueueCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [4:0] {
    TK_IDENT, TK_KEYWORD, TK_NUMBER, TK_ADD, TK_SUB, TK_MUL, TK_POWER, TK_DIV,
    TK_COMMENT, TK_CSTART, TK_CEND, TK_EQ, TK_EQEQ, TK_GT, TK_GE, TK_LT, TK_LE,
    TK_COMMA, TK_SEMI, TK_LPAREN, TK_RPAREN, TK_LSQUARE, TK_RSQUARE, TK_LCURLY,
    TK_RCURLY, TK_SQUOTE, TK_DQUOTE, TK_AT, TK_PERCENT, TK_HASH, TK_BSLASH,
    TK_ERROR
  } kind_e;

  typedef enum logic [1:0] {RUN_NONE, RUN_NUM, RUN_IDENT} run_e;

  typedef enum logic [2:0] {OP_NONE, OP_STAR, OP_SLASH, OP_EQ, OP_GT, OP_LT} op_e;

  // Keyword match progress: 7 = whole word seen, 8 = mismatch
  localparam logic [3:0] KpDone = 4'd7;
  localparam logic [3:0] KpFail = 4'd8;

  typedef struct packed {
    kind_e             kind;
    logic [ColW-1:0]   col_start;
    logic [ColW-1:0]   col_end;
    logic [CharW-1:0]  bad_char;
    logic              last;
  } token_t;

  // Tokens produced by one character: count plus two slots in order
  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } scan_res_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } kind_hit_t;

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [CharW-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // Characters of the keyword "circuit"
  function automatic logic [CharW-1:0] kw_char(logic [3:0] idx);
    logic [CharW-1:0] r;
    case (idx)
      4'd0:    r = "c";
      4'd1:    r = "i";
      4'd2:    r = "r";
      4'd3:    r = "c";
      4'd4:    r = "u";
      4'd5:    r = "i";
      4'd6:    r = "t";
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic op_e op_code(logic [CharW-1:0] c);
    op_e r;
    case (c)
      "*":     r = OP_STAR;
      "/":     r = OP_SLASH;
      "=":     r = OP_EQ;
      ">":     r = OP_GT;
      "<":     r = OP_LT;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  // Two-character operator formed by a waiting operator and the next character
  function automatic kind_hit_t pair_kind(op_e op, logic [CharW-1:0] c);
    kind_hit_t r;
    r = '{hit: 1'b0, kind: TK_IDENT};
    unique case (op)
      OP_STAR: begin
        if (c == "*") r = '{hit: 1'b1, kind: TK_POWER};
        else if (c == "/") r = '{hit: 1'b1, kind: TK_CEND};
      end
      OP_SLASH: begin
        if (c == "/") r = '{hit: 1'b1, kind: TK_COMMENT};
        else if (c == "*") r = '{hit: 1'b1, kind: TK_CSTART};
      end
      OP_EQ: if (c == "=") r = '{hit: 1'b1, kind: TK_EQEQ};
      OP_GT: if (c == "=") r = '{hit: 1'b1, kind: TK_GE};
      OP_LT: if (c == "=") r = '{hit: 1'b1, kind: TK_LE};
      default: r = '{hit: 1'b0, kind: TK_IDENT};
    endcase
    return r;
  endfunction

  function automatic kind_e single_kind(op_e op);
    kind_e r;
    unique case (op)
      OP_STAR:  r = TK_MUL;
      OP_SLASH: r = TK_DIV;
      OP_EQ:    r = TK_EQ;
      OP_GT:    r = TK_GT;
      OP_LT:    r = TK_LT;
      default:  r = TK_IDENT;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t punct_kind(logic [CharW-1:0] c);
    kind_hit_t r;
    r.hit = 1'b1;
    case (c)
      "+":     r.kind = TK_ADD;
      "-":     r.kind = TK_SUB;
      ",":     r.kind = TK_COMMA;
      ";":     r.kind = TK_SEMI;
      "(":     r.kind = TK_LPAREN;
      ")":     r.kind = TK_RPAREN;
      "[":     r.kind = TK_LSQUARE;
      "]":     r.kind = TK_RSQUARE;
      "{":     r.kind = TK_LCURLY;
      "}":     r.kind = TK_RCURLY;
      8'h27:   r.kind = TK_SQUOTE;
      8'h22:   r.kind = TK_DQUOTE;
      "@":     r.kind = TK_AT;
      "%":     r.kind = TK_PERCENT;
      "#":     r.kind = TK_HASH;
      8'h5C:   r.kind = TK_BSLASH;
      default: begin
        r.hit  = 1'b0;
        r.kind = TK_ERROR;
      end
    endcase
    return r;
  endfunction

  function automatic kind_e run_kind_tok(run_e run, logic [3:0] kp);
    kind_e r;
    if (run == RUN_NUM) r = TK_NUMBER;
    else if (kp == KpDone) r = TK_KEYWORD;
    else r = TK_IDENT;
    return r;
  endfunction

  function automatic token_t mk_token(kind_e kind, logic [ColW-1:0] s,
                                     logic [ColW-1:0] e, logic [CharW-1:0] bad);
    token_t t;
    t.kind      = kind;
    t.col_start = s;
    t.col_end   = e;
    t.bad_char  = bad;
    t.last      = 1'b0;
    return t;
  endfunction

endpackage

/* rtl/core/cll_queue.sv */
// Small token queue between the scanner and the output channel.
// Takes up to two tokens per cycle, hands out one per cycle while pop_i is high. Depends on cll_pkg.
module cll_queue
  import cll_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_res_t push_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output token_t    head_o
);

  token_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;
  logic                   pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // Room for a full pair of tokens
  assign room_o  = (cnt_q <= QueueCntW'(QueueDepth - 2));

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_i.n);
    rd_ptr_d = rd_ptr_q + QueuePtrW'(pop);
    cnt_d    = cnt_q + QueueCntW'(push_i.n) - QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Token storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_q + QueuePtrW'(1)] <= push_i.tok1;
  end

endmodule

/* rtl/core/cll_scan.sv */
// Lexer scanner: column, pending run and waiting operator state, plus the
// per-character token logic. Depends on cll_pkg.
module cll_scan
  import cll_pkg::*;
#(
  parameter int unsigned LINE_MAX = LineMaxDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] ch_i,
  input  logic             line_end_i,
  output scan_res_t        res_o
);

  localparam int unsigned ColBits = $clog2(LINE_MAX + 1);

  logic [ColBits-1:0] column_q, column_d, start_q, start_d;
  run_e               run_q, run_d;
  op_e                op_q, op_d;
  logic [3:0]         kp_q, kp_d;

  logic [ColBits-1:0] p, np;
  logic               used, a_v, b_v, c_v;
  token_t             a_tok, b_tok, c_tok;
  kind_hit_t          pk, ph;
  logic [ColW-1:0]    p_o, np_o;

  // Column of this character and the one after, saturating at the limit
  assign p    = column_q;
  assign np   = (p < ColBits'(LINE_MAX)) ? p + ColBits'(1) : ColBits'(LINE_MAX);
  assign p_o  = ColW'(p);
  assign np_o = ColW'(np);

  // Token decisions for one character
  always_comb begin
    used     = 1'b0;
    a_v      = 1'b0;
    b_v      = 1'b0;
    c_v      = 1'b0;
    a_tok    = '0;
    b_tok    = '0;
    c_tok    = '0;
    run_d    = run_q;
    start_d  = start_q;
    op_d     = op_q;
    kp_d     = kp_q;
    pk       = pair_kind(op_q, ch_i);
    ph       = punct_kind(ch_i);
    column_d = np;

    // Resolve a waiting operator
    if (op_q != OP_NONE) begin
      a_v = 1'b1;
      if (pk.hit) begin
        a_tok = mk_token(pk.kind, ColW'(start_q), np_o, '0);
        used  = 1'b1;
      end else begin
        a_tok = mk_token(single_kind(op_q), ColW'(start_q), p_o, '0);
      end
      op_d = OP_NONE;
    end

    // Extend or close a pending run
    if (!used && run_q != RUN_NONE) begin
      if (run_q == RUN_NUM && (is_digit(ch_i) || ch_i == ".")) begin
        used = 1'b1;
      end else if (run_q == RUN_IDENT &&
                   (is_alpha(ch_i) || is_digit(ch_i) || ch_i == "_")) begin
        if (kp_q < KpDone && ch_i == kw_char(kp_q)) kp_d = kp_q + 4'd1;
        else kp_d = KpFail;
        used = 1'b1;
      end else begin
        a_v   = 1'b1;
        a_tok = mk_token(run_kind_tok(run_q, kp_q), ColW'(start_q), p_o, '0);
        run_d = RUN_NONE;
      end
    end

    // Start something new with this character
    if (!used && ch_i != " ") begin
      if (is_digit(ch_i) || ch_i == ".") begin
        run_d   = RUN_NUM;
        start_d = p;
      end else if (is_alpha(ch_i)) begin
        run_d   = RUN_IDENT;
        start_d = p;
        kp_d    = (ch_i == kw_char(4'd0)) ? 4'd1 : KpFail;
      end else if (op_code(ch_i) != OP_NONE) begin
        op_d    = op_code(ch_i);
        start_d = p;
      end else begin
        b_v = 1'b1;
        if (ph.hit) b_tok = mk_token(ph.kind, p_o, np_o, '0);
        else b_tok = mk_token(TK_ERROR, p_o, np_o, ch_i);
      end
    end

    // Line end flushes whatever is pending and returns to reset state
    if (line_end_i) begin
      if (op_d != OP_NONE) begin
        c_v   = 1'b1;
        c_tok = mk_token(single_kind(op_d), ColW'(start_d), np_o, '0);
      end else if (run_d != RUN_NONE) begin
        c_v   = 1'b1;
        c_tok = mk_token(run_kind_tok(run_d, kp_d), ColW'(start_d), np_o, '0);
      end
      column_d = '0;
      run_d    = RUN_NONE;
      start_d  = '0;
      op_d     = OP_NONE;
      kp_d     = '0;
    end
  end

  // Pack tokens in order; at most two of the three slots are ever used
  always_comb begin
    res_o = '0;
    if (step_i) begin
      res_o.n = 2'(a_v) + 2'(b_v) + 2'(c_v);
      if (a_v) begin
        res_o.tok0 = a_tok;
        res_o.tok1 = b_v ? b_tok : c_tok;
      end else if (b_v) begin
        res_o.tok0 = b_tok;
        res_o.tok1 = c_tok;
      end else begin
        res_o.tok0 = c_tok;
      end
      if (res_o.n == 2'd1) res_o.tok0.last = 1'b1;
      if (res_o.n == 2'd2) res_o.tok1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      start_q  <= '0;
      run_q    <= RUN_NONE;
      op_q     <= OP_NONE;
      kp_q     <= '0;
    end else if (step_i) begin
      column_q <= column_d;
      start_q  <= start_d;
      run_q    <= run_d;
      op_q     <= op_d;
      kp_q     <= kp_d;
    end
  end

endmodule

/* rtl/core/circuit_language_lexer.sv */
// Top level of the streaming lexer: input register, scanner, token queue.
// Depends on cll_pkg, cll_scan and cll_queue.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | into      | in_valid_i / in_stall_o  | ch_i, line_end_i
//   out     | out of    | out_valid_o / out_stall_i| token_kind_o, col_start_o,
//           |           |                          | col_end_o, bad_char_o, last_o
//
// One character per cycle while in_stall_o is low: a character waits in the input register
// until the queue has room for a pair, and its tokens are written into the queue as it steps.
// The output port moves one token per cycle while out_stall_i is low, so a character
// that yields two tokens outpaces it; the 4-entry queue absorbs the difference.
// in_stall_o rises when a character is held while the queue lacks room for two.
// Reset clears the column, pending run, waiting operator and the queue.
module circuit_language_lexer
  import cll_pkg::*;
#(
  parameter int unsigned LINE_MAX = LineMaxDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] ch_i,
  input  logic             line_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [4:0]       token_kind_o,
  output logic [ColW-1:0]  col_start_o,
  output logic [ColW-1:0]  col_end_o,
  output logic [CharW-1:0] bad_char_o,
  output logic             last_o
);

  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] ch_q;
  logic             line_end_q;
  logic             room, step, accept;
  scan_res_t        res;
  token_t           head;

  // Input register advances whenever the queue has room for a pair
  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (step ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q       <= ch_i;
      line_end_q <= line_end_i;
    end
  end

  cll_scan #(
    .LINE_MAX(LINE_MAX)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ch_i       (ch_q),
    .line_end_i (line_end_q),
    .res_o      (res)
  );

  cll_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // Output transaction fields
  assign token_kind_o = head.kind;
  assign col_start_o  = head.col_start;
  assign col_end_o    = head.col_end;
  assign bad_char_o   = head.bad_char;
  assign last_o       = head.last;

endmodule

/* rtl/core/cll_checker.sv */
// Port-level checks on the lexer output channel, bound to the top level.
// Depends on cll_pkg and circuit_language_lexer_assert.svh.
`include "circuit_language_lexer_assert.svh"

module cll_checker
  import cll_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [4:0]       token_kind_o,
  input logic [ColW-1:0]  col_start_o,
  input logic [ColW-1:0]  col_end_o,
  input logic [CharW-1:0] bad_char_o,
  input logic             last_o
);

  // Only error tokens carry a character code
  `CLL_ASSERT_IMPL(a_bad_char_only_error, out_valid_o && token_kind_o != TK_ERROR, bad_char_o == '0, "bad_char set on a non-error token")

  // An error token is one column wide, or zero wide once the column saturates
  `CLL_ASSERT_IMPL(a_error_width, out_valid_o && token_kind_o == TK_ERROR, (col_end_o == col_start_o + 11'd1) || (col_end_o == col_start_o), "error token width wrong")

  // A keyword never spans more than the seven letters of the word
  `CLL_ASSERT_IMPL(a_keyword_width, out_valid_o && token_kind_o == TK_KEYWORD, (col_end_o - col_start_o) <= 11'd7, "keyword token too wide")

  // A stalled token stays put
  `CLL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(token_kind_o) && $stable(col_start_o) && $stable(col_end_o) && $stable(bad_char_o) && $stable(last_o), "output transaction changed while stalled")

endmodule

bind circuit_language_lexer cll_checker u_cll_checker (.*);

/* bench/tb.sv */
// Self-checking bench for circuit_language_lexer: character stream in, token stream out.
// Depends on cll_pkg for the token kinds and enums and on the lexer RTL.
// A behavioral lexer predicts every token; a monitor compares each output transaction.
module tb;
  import cll_pkg::*;

  typedef logic [CharW-1:0] byte_q_t[$];

  localparam int unsigned LineMax = LineMaxDefault;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [CharW-1:0] ch_i        = '0;
  logic             line_end_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [4:0]       token_kind_o;
  logic [ColW-1:0]  col_start_o;
  logic [ColW-1:0]  col_end_o;
  logic [CharW-1:0] bad_char_o;
  logic             last_o;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int mismatches   = 0;

  // Behavioral lexer state
  logic [ColW-1:0] col_q   = '0;
  logic [ColW-1:0] start_q = '0;
  run_e            run_q   = RUN_NONE;
  op_e             op_q    = OP_NONE;
  logic [3:0]      kwp_q   = '0;

  token_t step_toks[$];
  token_t tokens_due[$];

  circuit_language_lexer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .col_start_o  (col_start_o),
    .col_end_o    (col_end_o),
    .bad_char_o   (bad_char_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_dec(logic [CharW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [CharW-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [CharW-1:0] kw_letter(logic [3:0] idx);
    string w;
    w = "circuit";
    return w[idx];
  endfunction

  // Append one character to a character queue
  function automatic void add_byte(ref byte_q_t q, input logic [CharW-1:0] b);
    q.insert(q.size(), b);
  endfunction

  // at most two tokens per character
  function automatic void add_tok(kind_e k, int s, int e, logic [CharW-1:0] b);
    token_t t;
    if (step_toks.size() < 2) begin
      t.kind      = k;
      t.col_start = s[ColW-1:0];
      t.col_end   = e[ColW-1:0];
      t.bad_char  = b;
      t.last      = 1'b0;
      step_toks.insert(step_toks.size(), t);
    end
  endfunction

  function automatic kind_e op_alone(op_e op);
    case (op)
      OP_STAR:  return TK_MUL;
      OP_SLASH: return TK_DIV;
      OP_EQ:    return TK_EQ;
      OP_GT:    return TK_GT;
      default:  return TK_LT;
    endcase
  endfunction

  function automatic void close_run(int e);
    if (run_q == RUN_NUM) add_tok(TK_NUMBER, start_q, e, '0);
    else if (run_q == RUN_IDENT)
      add_tok(kwp_q == KpDone ? TK_KEYWORD : TK_IDENT, start_q, e, '0);
    run_q = RUN_NONE;
  endfunction

  function automatic void lex_char(logic [CharW-1:0] c, logic eol);
    int     p;
    int     np;
    logic   used;
    logic   hit;
    kind_e  k;
    op_e    nop;
    p    = col_q;
    np   = (p < LineMax) ? p + 1 : LineMax;
    used = 1'b0;
    k    = TK_IDENT;
    step_toks.delete();

    // resolve a waiting operator against this character
    if (op_q != OP_NONE) begin
      hit = 1'b1;
      case (op_q)
        OP_STAR:  if (c == "*") k = TK_POWER;   else if (c == "/") k = TK_CEND;   else hit = 1'b0;
        OP_SLASH: if (c == "/") k = TK_COMMENT; else if (c == "*") k = TK_CSTART; else hit = 1'b0;
        OP_EQ:    if (c == "=") k = TK_EQEQ; else hit = 1'b0;
        OP_GT:    if (c == "=") k = TK_GE;   else hit = 1'b0;
        default:  if (c == "=") k = TK_LE;   else hit = 1'b0;
      endcase
      if (hit) begin
        add_tok(k, start_q, np, '0);
        used = 1'b1;
      end else begin
        add_tok(op_alone(op_q), start_q, p, '0);
      end
      op_q = OP_NONE;
    end

    // extend or close a pending run
    if (!used && run_q != RUN_NONE) begin
      if (run_q == RUN_NUM && (is_dec(c) || c == ".")) begin
        used = 1'b1;
      end else if (run_q == RUN_IDENT && (is_letter(c) || is_dec(c) || c == "_")) begin
        if (kwp_q < KpDone && c == kw_letter(kwp_q)) kwp_q++;
        else kwp_q = KpFail;
        used = 1'b1;
      end else begin
        close_run(p);
      end
    end

    // start something new
    if (!used && c != " ") begin
      case (c)
        "*":     nop = OP_STAR;
        "/":     nop = OP_SLASH;
        "=":     nop = OP_EQ;
        ">":     nop = OP_GT;
        "<":     nop = OP_LT;
        default: nop = OP_NONE;
      endcase
      if (is_dec(c) || c == ".") begin
        run_q   = RUN_NUM;
        start_q = p[ColW-1:0];
      end else if (is_letter(c)) begin
        run_q   = RUN_IDENT;
        start_q = p[ColW-1:0];
        kwp_q   = (c == "c") ? 4'd1 : KpFail;
      end else if (nop != OP_NONE) begin
        op_q    = nop;
        start_q = p[ColW-1:0];
      end else begin
        hit = 1'b1;
        case (c)
          "+":     k = TK_ADD;
          "-":     k = TK_SUB;
          ",":     k = TK_COMMA;
          ";":     k = TK_SEMI;
          "(":     k = TK_LPAREN;
          ")":     k = TK_RPAREN;
          "[":     k = TK_LSQUARE;
          "]":     k = TK_RSQUARE;
          "{":     k = TK_LCURLY;
          "}":     k = TK_RCURLY;
          "'":     k = TK_SQUOTE;
          "\"":    k = TK_DQUOTE;
          "@":     k = TK_AT;
          "%":     k = TK_PERCENT;
          "#":     k = TK_HASH;
          "\\":    k = TK_BSLASH;
          default: hit = 1'b0;
        endcase
        if (hit) add_tok(k, p, np, '0);
        else add_tok(TK_ERROR, p, np, c);
      end
    end

    // line end flushes everything and restarts the column
    if (eol) begin
      if (op_q != OP_NONE) add_tok(op_alone(op_q), start_q, np, '0);
      else if (run_q != RUN_NONE) close_run(np);
      col_q   = '0;
      run_q   = RUN_NONE;
      start_q = '0;
      op_q    = OP_NONE;
      kwp_q   = '0;
    end else begin
      col_q = np[ColW-1:0];
    end

    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Output monitor: stall/valid/payload are stable from negedge to the next edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d cols %0d..%0d bad %0h last %0b",
                   token_kind_o, col_start_o, col_end_o, bad_char_o, last_o);
      end else begin
        want = tokens_due.pop_front();
        if (token_kind_o != want.kind || col_start_o != want.col_start ||
            col_end_o != want.col_end || bad_char_o != want.bad_char ||
            last_o != want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch: exp kind %0d cols %0d..%0d bad %0h last %0b",
                     want.kind, want.col_start, want.col_end, want.bad_char, want.last);
            $display("                got kind %0d cols %0d..%0d bad %0h last %0b",
                     token_kind_o, col_start_o, col_end_o, bad_char_o, last_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // One input transaction; valid is only lowered when a gap is taken
  task automatic send_char(input logic [CharW-1:0] c, input logic last_char);
    int   gap;
    logic stalled;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    line_end_i <= last_char;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    lex_char(c, last_char);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  // Hold the sender off until every predicted token has come out
  task automatic wait_for_tokens();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tokens_due.size() != 0);
  endtask

  function automatic logic [CharW-1:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  // One random lexeme, mostly well formed, some noise
  function automatic byte_q_t lexeme();
    byte_q_t q;
    string   w;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0:       w = "circuit";
          1:       w = "circuits";
          2:       w = "circ";
          3:       w = "Circuit";
          4:       w = "circuit_";
          default: w = "c1rcuit";
        endcase
        foreach (w[i]) add_byte(q, w[i]);
      end else begin
        add_byte(q, rand_letter());
        repeat ($urandom_range(5)) begin
          case ($urandom_range(2))
            0:       add_byte(q, rand_letter());
            1:       add_byte(q, 8'($urandom_range(48, 57)));
            default: add_byte(q, "_");
          endcase
        end
      end
    end else if (pick < 35) begin
      repeat ($urandom_range(5, 1))
        add_byte(q, $urandom_range(4) == 0 ? 8'h2E : 8'($urandom_range(48, 57)));
    end else if (pick < 55) begin
      w = "*/=><";
      add_byte(q, w[$urandom_range(4)]);
      w = "*/=";
      if ($urandom_range(1)) add_byte(q, w[$urandom_range(2)]);
    end else if (pick < 70) begin
      w = "+-,;()[]{}'\"@%#\\";
      add_byte(q, w[$urandom_range(15)]);
    end else if (pick < 90) begin
      repeat ($urandom_range(2, 1)) add_byte(q, " ");
    end else begin
      case ($urandom_range(3))
        0:       add_byte(q, "_");
        1:       add_byte(q, 8'h09);
        default: add_byte(q, 8'($urandom_range(255)));
      endcase
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Keyword, every two-character operator and every lone operator
  task automatic test_operators();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_text("circuit");
    send_text("**/*==");
    send_text("*/>=<=//");
    send_text("*=>< /");
    send_text("9");
  endtask

  // Lowest and highest byte codes are unknown characters
  task automatic test_unknown_chars();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_random_text(input int tx, input int rx, input int n_chars);
    byte_q_t line;
    byte_q_t lx;
    int      sent;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    sent         = 0;
    while (sent < n_chars) begin
      line.delete();
      repeat ($urandom_range(8, 1)) begin
        lx = lexeme();
        foreach (lx[i]) add_byte(line, lx[i]);
      end
      send_bytes(line);
      sent += line.size();
    end
  endtask

  // One line running past the column limit
  task automatic test_column_saturation();
    byte_q_t line;
    byte_q_t lx;
    tx_idle_pct  = 37;
    rx_stall_pct = 37;
    while (line.size() < LineMax + 16) begin
      lx = lexeme();
      foreach (lx[i]) add_byte(line, lx[i]);
    end
    send_bytes(line);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operators();
    test_unknown_chars();
    test_random_text(0, 0, 60);
    wait_for_tokens();
    test_random_text(50, 0, 60);
    test_random_text(0, 50, 60);
    wait_for_tokens();
    test_random_text(37, 37, 60);
    test_column_saturation();

    wait_for_tokens();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("circuit_language_lexer: match");
    end else begin
      $display("circuit_language_lexer: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("circuit_language_lexer: mismatch");
    $finish;
  end

endmodule
